/* rtl/core/swcf_pkg.sv */
package swcf_pkg;

  localparam logic [1:0] OP_CMD     = 2'd0;
  localparam logic [1:0] OP_CMD_VAL = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RX_BYTE = 2'd3;

  localparam logic       KIND_TX   = 1'b0;
  localparam logic       KIND_WORD = 1'b1;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  localparam logic [1:0] MAX_WORDS = 2'd3;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    JOB_CMD,
    JOB_CMD_VAL,
    JOB_WORD
  } job_kind_e;

  // One queued job: a transmit run or one checked received word.
  typedef struct packed {
    job_kind_e   kind;
    logic [15:0] cmd;
    logic [15:0] word;
    logic        crc_ok;
    logic        last;
  } job_t;

  // Shift one byte through the CRC register, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/swcf_fifo.sv */
module swcf_fifo #(
  parameter int unsigned DEPTH = swcf_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swcf_pkg::job_t push_data_i,
  input  logic           pop_i,
  output swcf_pkg::job_t head_o,
  output logic           valid_o,
  output logic           full_o
);
  import swcf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/swcf_front.sv */
module swcf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     opcode_i,
  input  logic [15:0]    command_code_i,
  input  logic [15:0]    value_word_i,
  input  logic [1:0]     expected_words_i,
  input  logic [7:0]     rx_byte_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output swcf_pkg::job_t q_job_o
);
  import swcf_pkg::*;

  localparam logic [1:0] POS_HI  = 2'd0;
  localparam logic [1:0] POS_LO  = 2'd1;
  localparam logic [1:0] POS_CHK = 2'd2;

  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  words_q, words_d;
  logic        aborted_q, aborted_d;
  logic [7:0]  crc_q, crc_d;
  logic        accept;
  logic        crc_match;
  logic [1:0]  count_sat;

  // Hold every request while the queue has no room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign crc_match  = (crc_q == rx_byte_i);

  always_comb begin
    if (expected_words_i == 2'd0) begin
      count_sat = 2'd1;
    end else if (expected_words_i > MAX_WORDS) begin
      count_sat = MAX_WORDS;
    end else begin
      count_sat = expected_words_i;
    end
  end

  always_comb begin
    byte_pos_d = byte_pos_q;
    held_d     = held_q;
    words_d    = words_q;
    aborted_d  = aborted_q;
    crc_d      = crc_q;
    q_push_o   = 1'b0;
    q_job_o    = '{kind: JOB_CMD, cmd: command_code_i, word: value_word_i,
                   crc_ok: 1'b0, last: 1'b1};
    if (accept) begin
      unique case (opcode_i)
        OP_CMD: begin
          q_push_o = 1'b1;
        end
        OP_CMD_VAL: begin
          q_push_o     = 1'b1;
          q_job_o.kind = JOB_CMD_VAL;
        end
        OP_READ: begin
          words_d    = count_sat;
          byte_pos_d = POS_HI;
          held_d     = '0;
          aborted_d  = 1'b0;
        end
        default: begin
          // Drop stray bytes outside an armed response.
          if (words_q != 2'd0 && !aborted_q) begin
            priority case (byte_pos_q)
              POS_HI: begin
                held_d     = {rx_byte_i, 8'h00};
                crc_d      = crc8_step(CRC_INIT ^ rx_byte_i);
                byte_pos_d = POS_LO;
              end
              POS_LO: begin
                held_d     = {held_q[15:8], rx_byte_i};
                crc_d      = crc8_step(crc_q ^ rx_byte_i);
                byte_pos_d = POS_CHK;
              end
              default: begin
                q_push_o       = 1'b1;
                q_job_o.kind   = JOB_WORD;
                q_job_o.word   = held_q;
                q_job_o.crc_ok = crc_match;
                q_job_o.last   = (words_q == 2'd1) || !crc_match;
                byte_pos_d     = POS_HI;
                words_d        = words_q - 2'd1;
                if (!crc_match) begin
                  aborted_d = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= POS_HI;
      held_q     <= '0;
      words_q    <= '0;
      aborted_q  <= 1'b0;
      crc_q      <= CRC_INIT;
    end else begin
      byte_pos_q <= byte_pos_d;
      held_q     <= held_d;
      words_q    <= words_d;
      aborted_q  <= aborted_d;
      crc_q      <= crc_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q != 2'd3)
    else $error("byte position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (words_q == 2'd0 || aborted_q) |-> byte_pos_q == POS_HI)
    else $error("idle receiver not at start of triple");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_job_o.kind == JOB_WORD && !q_job_o.crc_ok) |=> aborted_q)
    else $error("crc error did not abort response");

endmodule

/* rtl/core/swcf_back.sv */
module swcf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  swcf_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           result_kind_o,
  output logic [7:0]     tx_byte_o,
  output logic [15:0]    data_word_o,
  output logic           crc_ok_o,
  output logic           last_o
);
  import swcf_pkg::*;

  localparam logic [2:0] IDX_CMD_HI = 3'd0;
  localparam logic [2:0] IDX_CMD_LO = 3'd1;
  localparam logic [2:0] IDX_VAL_HI = 3'd2;
  localparam logic [2:0] IDX_VAL_LO = 3'd3;
  localparam logic [2:0] IDX_CRC    = 3'd4;

  logic [2:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  tx_q, tx_d;
  logic [15:0] word_q, word_d;
  logic        ok_q, ok_d;
  logic        last_q, last_d;
  logic        emit;
  logic        final_res;

  assign emit  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && final_res;

  always_comb begin
    final_res = 1'b1;
    kind_d    = KIND_TX;
    tx_d      = '0;
    word_d    = '0;
    ok_d      = 1'b0;
    last_d    = 1'b0;
    unique case (head_i.kind)
      JOB_CMD: begin
        final_res = (idx_q == IDX_CMD_LO);
        tx_d      = final_res ? head_i.cmd[7:0] : head_i.cmd[15:8];
        last_d    = final_res;
      end
      JOB_CMD_VAL: begin
        final_res = (idx_q == IDX_CRC);
        last_d    = final_res;
        unique case (idx_q)
          IDX_CMD_HI: tx_d = head_i.cmd[15:8];
          IDX_CMD_LO: tx_d = head_i.cmd[7:0];
          IDX_VAL_HI: tx_d = head_i.word[15:8];
          IDX_VAL_LO: tx_d = head_i.word[7:0];
          default:    tx_d = crc8_step(crc_q ^ head_i.word[7:0]);
        endcase
      end
      JOB_WORD: begin
        kind_d = KIND_WORD;
        word_d = head_i.word;
        ok_d   = head_i.crc_ok;
        last_d = head_i.last;
      end
      default: begin
        final_res = 1'b1;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (emit) begin
      idx_d = final_res ? IDX_CMD_HI : idx_q + 3'd1;
      // Fold in the value's high byte early; the low byte closes it on the last byte.
      if (idx_q == IDX_CMD_HI) begin
        crc_d = crc8_step(CRC_INIT ^ head_i.word[15:8]);
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IDX_CMD_HI;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      tx_q   <= tx_d;
      word_q <= word_d;
      ok_q   <= ok_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign tx_byte_o     = tx_q;
  assign data_word_o   = word_q;
  assign crc_ok_o      = ok_q;
  assign last_o        = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_CRC)
    else $error("byte index past end of frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_TX) |-> (word_q == 16'h0000 && !ok_q))
    else $error("transmit result carries word fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_WORD && !ok_q) |-> (last_q && tx_q == 8'h00))
    else $error("bad word result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && head_i.kind == JOB_WORD) |-> idx_q == IDX_CMD_HI)
    else $error("word job started mid frame");

endmodule

/* rtl/core/sensor_word_crc_framer.sv */
// Each request that yields output is written into the job queue; its results leave through the output register.
// Throughput: one request accepted per cycle while the job queue has room; the output side
// emits one result per cycle unless stalled; a command with value yields five results,
// a plain command two and a received word one.
// Reset: rst_ni clears the receive state, the job queue and the output valid flag at once.
module sensor_word_crc_framer #(
  parameter int unsigned FIFO_DEPTH = swcf_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] command_code_i,
  input  logic [15:0] value_word_i,
  input  logic [1:0]  expected_words_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [15:0] data_word_o,
  output logic        crc_ok_o,
  output logic        last_o
);
  import swcf_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t q_job, q_head;

  swcf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .command_code_i   (command_code_i),
    .value_word_i     (value_word_i),
    .expected_words_i (expected_words_i),
    .rx_byte_i        (rx_byte_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_job_o          (q_job)
  );

  swcf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_job),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .valid_o     (q_valid),
    .full_o      (q_full)
  );

  swcf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .tx_byte_o     (tx_byte_o),
    .data_word_o   (data_word_o),
    .crc_ok_o      (crc_ok_o),
    .last_o        (last_o)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import swcf_pkg::*;

  localparam int unsigned REQUEST_TARGET = 360;
  localparam int unsigned HOLD_AFTER_REQS = 120;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    logic [1:0]  opcode;
    logic [15:0] command_code;
    logic [15:0] value_word;
    logic [1:0]  expected_words;
    logic [7:0]  rx_byte;
    int unsigned idle_cycles;
  } bus_request_t;

  typedef struct {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [15:0] data_word;
    logic        crc_ok;
    logic        last;
  } framer_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OP_CMD;
  logic [15:0] command_code_i = 16'h0000;
  logic [15:0] value_word_i = 16'h0000;
  logic [1:0]  expected_words_i = 2'd0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [7:0]  tx_byte_o;
  logic [15:0] data_word_o;
  logic        crc_ok_o;
  logic        last_o;

  sensor_word_crc_framer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .command_code_i   (command_code_i),
    .value_word_i     (value_word_i),
    .expected_words_i (expected_words_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .tx_byte_o        (tx_byte_o),
    .data_word_o      (data_word_o),
    .crc_ok_o         (crc_ok_o),
    .last_o           (last_o)
  );

  bus_request_t   request_q[$];
  framer_result_t expected_results[$];
  framer_result_t oldest;

  // receive-side shadow state
  logic [1:0]  rx_pos;
  logic [15:0] rx_held;
  logic [1:0]  words_left;
  logic        rx_aborted;

  int unsigned fill_count;
  int unsigned mismatch_count;
  int unsigned accepted_requests;
  int unsigned result_count;
  int unsigned quiet_cycles;
  int unsigned idle_count;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_started;
  bit          req_taken;
  bit          res_taken;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // CRC-8, poly 0x31, init 0xFF, bit-serial MSB first over both bytes
  function automatic logic [7:0] word_check_byte(input logic [15:0] w);
    logic [7:0] c;
    logic       fb;
    c = CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ w[i];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: %s", $realtime, what);
  endtask

  task automatic push_tx(input logic [7:0] b, input logic is_last);
    framer_result_t r;
    r.kind = KIND_TX;
    r.tx_byte = b;
    r.data_word = 16'h0000;
    r.crc_ok = 1'b0;
    r.last = is_last;
    expected_results.push_back(r);
  endtask

  task automatic predict_framer(input logic [1:0] op, input logic [15:0] cmd,
                                input logic [15:0] val, input logic [1:0] cnt,
                                input logic [7:0] rx);
    framer_result_t r;
    logic           ok;
    case (op)
      OP_CMD: begin
        push_tx(cmd[15:8], 1'b0);
        push_tx(cmd[7:0], 1'b1);
      end
      OP_CMD_VAL: begin
        push_tx(cmd[15:8], 1'b0);
        push_tx(cmd[7:0], 1'b0);
        push_tx(val[15:8], 1'b0);
        push_tx(val[7:0], 1'b0);
        push_tx(word_check_byte(val), 1'b1);
      end
      OP_READ: begin
        words_left = (cnt == 2'd0) ? 2'd1 : ((cnt > MAX_WORDS) ? MAX_WORDS : cnt);
        rx_pos = 2'd0;
        rx_held = 16'h0000;
        rx_aborted = 1'b0;
      end
      default: begin
        if (words_left != 2'd0 && !rx_aborted) begin
          if (rx_pos == 2'd0) begin
            rx_held = {rx, 8'h00};
            rx_pos = 2'd1;
          end else if (rx_pos == 2'd1) begin
            rx_held[7:0] = rx;
            rx_pos = 2'd2;
          end else begin
            ok = (word_check_byte(rx_held) == rx);
            r.kind = KIND_WORD;
            r.tx_byte = 8'h00;
            r.data_word = rx_held;
            r.crc_ok = ok;
            r.last = (words_left == 2'd1) || !ok;
            expected_results.push_back(r);
            rx_pos = 2'd0;
            words_left = words_left - 2'd1;
            if (!ok) begin
              rx_aborted = 1'b1;
            end
          end
        end
      end
    endcase
  endtask

  task automatic add_request(input logic [1:0] op, input logic [15:0] cmd,
                             input logic [15:0] val, input logic [1:0] cnt,
                             input logic [7:0] rx);
    bus_request_t r;
    r.opcode = op;
    r.command_code = cmd;
    r.value_word = val;
    r.expected_words = cnt;
    r.rx_byte = rx;
    // every third stretch of 40 requests goes back to back
    r.idle_cycles = ((fill_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 15);
    request_q.push_back(r);
    fill_count++;
  endtask

  task automatic send_rx_byte(input logic [7:0] b);
    add_request(OP_RX_BYTE, 16'($urandom), 16'($urandom), 2'($urandom), b);
  endtask

  task automatic send_triple(input logic [15:0] w, input bit good);
    logic [7:0] chk;
    chk = word_check_byte(w);
    if (!good) begin
      chk = chk ^ 8'($urandom_range(1, 255));
    end
    send_rx_byte(w[15:8]);
    send_rx_byte(w[7:0]);
    send_rx_byte(chk);
  endtask

  task automatic send_transmit();
    add_request(($urandom_range(0, 1) == 0) ? OP_CMD : OP_CMD_VAL,
                16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
  endtask

  // driver: present requests at the falling edge, hold until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (request_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_count < request_q[0].idle_cycles) begin
          in_valid_i <= 1'b0;
          idle_count++;
        end else begin
          opcode_i         <= request_q[0].opcode;
          command_code_i   <= request_q[0].command_code;
          value_word_i     <= request_q[0].value_word;
          expected_words_i <= request_q[0].expected_words;
          rx_byte_i        <= request_q[0].rx_byte;
          in_valid_i       <= 1'b1;
          void'(request_q.pop_front());
          idle_count = 0;
        end
      end
    end
  end

  // receiver: random stall per result, plus one long hold to back up the queue
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        stall_left = ((result_count / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
      end
      if (!hold_started && accepted_requests >= HOLD_AFTER_REQS) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: predict on each taken request, check each taken result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken = 1'b0;
      res_taken = 1'b0;
    end else begin
      req_taken = in_valid_i && !in_stall_o;
      res_taken = out_valid_o && !out_stall_i;
      if (req_taken) begin
        predict_framer(opcode_i, command_code_i, value_word_i, expected_words_i, rx_byte_i);
        accepted_requests++;
      end
      if (res_taken) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d tx=%02h word=%04h ok=%0d last=%0d",
                                    result_kind_o, tx_byte_o, data_word_o, crc_ok_o, last_o));
        end else begin
          oldest = expected_results.pop_front();
          if (result_kind_o !== oldest.kind)
            report_mismatch($sformatf("result_kind %0d, predicted %0d", result_kind_o, oldest.kind));
          if (tx_byte_o !== oldest.tx_byte)
            report_mismatch($sformatf("tx_byte %02h, predicted %02h", tx_byte_o, oldest.tx_byte));
          if (data_word_o !== oldest.data_word)
            report_mismatch($sformatf("data_word %04h, predicted %04h", data_word_o,
                                      oldest.data_word));
          if (crc_ok_o !== oldest.crc_ok)
            report_mismatch($sformatf("crc_ok %0d, predicted %0d", crc_ok_o, oldest.crc_ok));
          if (last_o !== oldest.last)
            report_mismatch($sformatf("last %0d, predicted %0d", last_o, oldest.last));
        end
      end
      if (req_taken || res_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog: %0d cycles without a handshake", QUIET_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    int          pick;
    int          n;
    int unsigned words;

    rx_pos = 2'd0;
    rx_held = 16'h0000;
    words_left = 2'd0;
    rx_aborted = 1'b0;

    // directed part
    send_rx_byte(8'hFF);                              // nothing armed: dropped
    add_request(OP_CMD, 16'h0000, 16'($urandom), 2'($urandom), 8'($urandom));
    add_request(OP_CMD, 16'hFFFF, 16'($urandom), 2'($urandom), 8'($urandom));
    add_request(OP_CMD_VAL, 16'hFFFF, 16'h0000, 2'($urandom), 8'($urandom));
    add_request(OP_CMD_VAL, 16'h0000, 16'hFFFF, 2'($urandom), 8'($urandom));
    add_request(OP_CMD_VAL, 16'h1234, 16'hBEEF, 2'($urandom), 8'($urandom));
    // zero count arms one word
    add_request(OP_READ, 16'($urandom), 16'($urandom), 2'd0, 8'($urandom));
    send_triple(16'hFFFF, 1'b1);
    send_rx_byte(8'h00);                              // response done: dropped
    add_request(OP_READ, 16'($urandom), 16'($urandom), 2'd3, 8'($urandom));
    send_triple(16'h0000, 1'b1);
    send_rx_byte(8'hA5);
    // transmit mid-triple
    add_request(OP_CMD, 16'h5AA5, 16'($urandom), 2'($urandom), 8'($urandom));
    send_rx_byte(8'h3C);
    send_rx_byte(word_check_byte(16'hA53C) ^ 8'h01);  // bad check byte ends the response
    send_rx_byte(8'h77);                              // after CRC error: dropped
    add_request(OP_READ, 16'($urandom), 16'($urandom), 2'd2, 8'($urandom));
    send_rx_byte(8'h11);
    // restart mid-response
    add_request(OP_READ, 16'($urandom), 16'($urandom), 2'd1, 8'($urandom));
    send_triple(16'h8001, 1'b1);

    // random part: mostly well-formed responses, some transmits and noise
    while (fill_count < REQUEST_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(0, 3);
        add_request(OP_READ, 16'($urandom), 16'($urandom), n[1:0], 8'($urandom));
        words = (n == 0) ? 1 : n;
        for (int k = 0; k < words; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_transmit();
          end
          send_triple(16'($urandom), $urandom_range(0, 7) != 0);
        end
        if ($urandom_range(0, 4) == 0) begin
          send_rx_byte(8'($urandom));
        end
      end else if (pick < 80) begin
        send_transmit();
      end else if (pick < 90) begin
        // truncated response
        add_request(OP_READ, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
        n = $urandom_range(1, 2);
        for (int k = 0; k < n; k++) begin
          send_rx_byte(8'($urandom));
        end
      end else begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          send_rx_byte(8'($urandom));
        end
      end
    end

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/swcf_pkg.sv
rtl/core/swcf_fifo.sv
rtl/core/swcf_front.sv
rtl/core/swcf_back.sv
rtl/core/sensor_word_crc_framer.sv
tb/tb_top.sv
